### rtl/core/cdo_pkg.sv
// Shared types, constants and helper functions for the calendar date offset unit.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package cdo_pkg;

    localparam int YEAR_BITS  = 14;
    localparam int COUNT_BITS = 10;

    localparam int OP_W     = 3;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int WDAY_W   = 3;
    localparam int STATUS_W = 2;
    localparam int REM_W    = 7;
    localparam int TERM_W   = 6;

    // year / 100 always fits in YEAR_BITS - 6 bits
    localparam int CENT_W      = YEAR_BITS - 6;
    localparam int STEP_W      = COUNT_BITS + 3;
    localparam int YSUM_W      = ((YEAR_BITS > COUNT_BITS + 4) ? YEAR_BITS : COUNT_BITS + 4) + 1;
    localparam int SUM_W       = 3 * ((CENT_W + 6) / 3);
    localparam int PROD_W      = 2 * YEAR_BITS + 1;
    localparam int RECIP_SHIFT = YEAR_BITS + 7;

    typedef logic [OP_W-1:0]       op_t;
    typedef logic [DAY_W-1:0]      day_t;
    typedef logic [MONTH_W-1:0]    month_t;
    typedef logic [YEAR_BITS-1:0]  year_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [WDAY_W-1:0]     wday_t;
    typedef logic [STATUS_W-1:0]   status_t;
    typedef logic [REM_W-1:0]      rem_t;
    typedef logic [CENT_W-1:0]     cent_t;
    typedef logic [STEP_W-1:0]     step_t;
    typedef logic [SUM_W-1:0]      wsum_t;

    localparam year_t YEAR_MAX = '1;
    localparam logic [YEAR_BITS:0] RECIP = (YEAR_BITS + 1)'((2 ** RECIP_SHIFT + 99) / 100);
    localparam rem_t REM_LAST = 7'd99;

    localparam op_t OP_DAYS    = 3'd0;
    localparam op_t OP_WEEKS   = 3'd1;
    localparam op_t OP_MONTHS  = 3'd2;
    localparam op_t OP_YEARS   = 3'd3;
    localparam op_t OP_DECADES = 3'd4;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_BAD_DATE = 2'd1;
    localparam status_t STATUS_YEAR_OVF = 2'd2;

    localparam month_t MONTH_FEB = 4'd2;
    localparam month_t MONTH_DEC = 4'd12;

    localparam day_t MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // (31 * shifted month) / 12, with January and February counted as months 11 and 12
    localparam logic [TERM_W-1:0] MONTH_TERM [12] = '{
        6'd28, 6'd31, 6'd2, 6'd5, 6'd7, 6'd10,
        6'd12, 6'd15, 6'd18, 6'd20, 6'd23, 6'd25
    };

    typedef struct packed {
        logic load;
        logic mul;
        logic split;
        logic check_invalid;
        logic years_ovf;
        logic years_add;
        logic steps_init;
        logic step;
        logic restore;
        logic wsum;
        logic wload;
    } cdo_cmd_t;

    typedef struct packed {
        logic date_bad;
        logic op_steps;
        logic op_years;
        logic count_zero;
        logic years_ovf;
        logic step_ovf;
        logic step_last;
    } cdo_stat_t;

    // Year given as year % 100 and year / 100
    function automatic logic is_leap(input rem_t rem, input cent_t cent);
        is_leap = (rem[1:0] == 2'b00) && ((rem != '0) || (cent[1:0] == 2'b00));
    endfunction

    function automatic day_t days_in(input logic leap, input month_t m);
        if ((m == '0) || (m > MONTH_DEC))
            days_in = '0;
        else if (m == MONTH_FEB)
            days_in = leap ? 5'd29 : 5'd28;
        else
            days_in = MONTH_LEN[4'(m - 4'd1)];
    endfunction

    function automatic logic [TERM_W-1:0] month_term(input month_t m);
        if ((m == '0) || (m > MONTH_DEC))
            month_term = '0;
        else
            month_term = MONTH_TERM[4'(m - 4'd1)];
    endfunction

    // 8 == 1 mod 7: add the octal digits, then fold twice
    function automatic wday_t mod7(input wsum_t v);
        logic [5:0] s1;
        logic [3:0] s2;
        s1 = '0;
        for (int g = 0; g < SUM_W / 3; g++)
            s1 = s1 + 6'(v[3*g +: 3]);
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        if (s2 >= 4'd14)
            mod7 = '0;
        else if (s2 >= 4'd7)
            mod7 = 3'(s2 - 4'd7);
        else
            mod7 = s2[2:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/cdo_if.sv
// Valid/ready channel interfaces for the date offset request and its result.
// Depends on cdo_pkg for the payload types.
`default_nettype none

interface cdo_req_if;
    logic            valid;
    logic            ready;
    cdo_pkg::op_t    operation;
    cdo_pkg::day_t   start_day;
    cdo_pkg::month_t start_month;
    cdo_pkg::year_t  start_year;
    cdo_pkg::count_t step_count;

    modport source (
        output valid, operation, start_day, start_month, start_year, step_count,
        input  ready
    );
    modport sink (
        input  valid, operation, start_day, start_month, start_year, step_count,
        output ready
    );
endinterface

interface cdo_rsp_if;
    logic             valid;
    logic             ready;
    cdo_pkg::day_t    new_day;
    cdo_pkg::month_t  new_month;
    cdo_pkg::year_t   new_year;
    cdo_pkg::wday_t   weekday;
    cdo_pkg::status_t status;

    modport source (
        output valid, new_day, new_month, new_year, weekday, status,
        input  ready
    );
    modport sink (
        input  valid, new_day, new_month, new_year, weekday, status,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/cdo_datapath.sv
// Datapath: date registers, year split by reciprocal multiply, day/month stepper,
// weekday sum and result register. Depends on cdo_pkg.
`default_nettype none

module cdo_datapath (
    input  logic                clk,
    input  cdo_pkg::cdo_cmd_t   cmd,
    output cdo_pkg::cdo_stat_t  stat,
    input  cdo_pkg::op_t        operation,
    input  cdo_pkg::day_t       start_day,
    input  cdo_pkg::month_t     start_month,
    input  cdo_pkg::year_t      start_year,
    input  cdo_pkg::count_t     step_count,
    output cdo_pkg::day_t       new_day,
    output cdo_pkg::month_t     new_month,
    output cdo_pkg::year_t      new_year,
    output cdo_pkg::wday_t      weekday,
    output cdo_pkg::status_t    status
);

    cdo_pkg::op_t                 op_reg;
    cdo_pkg::count_t              n_reg;
    cdo_pkg::day_t                d_reg, d0_reg;
    cdo_pkg::month_t              m_reg, m0_reg;
    cdo_pkg::year_t               y_reg, y0_reg;
    cdo_pkg::rem_t                rem_reg, rem0_reg;
    cdo_pkg::cent_t               cent_reg, cent0_reg;
    logic [cdo_pkg::PROD_W-1:0]   prod_reg;
    cdo_pkg::step_t               steps_reg;
    cdo_pkg::status_t             status_reg;
    cdo_pkg::wsum_t               wsum_reg;

    cdo_pkg::day_t                out_day_reg;
    cdo_pkg::month_t              out_month_reg;
    cdo_pkg::year_t               out_year_reg;
    cdo_pkg::wday_t               out_wday_reg;
    cdo_pkg::status_t             out_status_reg;

    cdo_pkg::cent_t               cent_q;
    cdo_pkg::rem_t                rem_q;
    logic                         leap_cur, leap_inc, leap_n, m_wrap;
    cdo_pkg::day_t                dim_cur, dim_n, d_clamp;
    cdo_pkg::month_t              m_next;
    cdo_pkg::rem_t                rem_inc;
    cdo_pkg::cent_t               cent_inc;
    cdo_pkg::day_t                d_step;
    cdo_pkg::month_t              m_step;
    cdo_pkg::year_t               y_step;
    cdo_pkg::rem_t                rem_step;
    cdo_pkg::cent_t               cent_step;
    logic [cdo_pkg::YSUM_W-1:0]   ysum;
    cdo_pkg::step_t               steps_init;
    logic                         shift_year;
    cdo_pkg::rem_t                w_rem;
    cdo_pkg::cent_t               w_cent;
    cdo_pkg::wsum_t               wsum_next;

    // year / 100 from the registered product, remainder by back-multiply
    assign cent_q = prod_reg[cdo_pkg::RECIP_SHIFT +: cdo_pkg::CENT_W];
    assign rem_q  = cdo_pkg::REM_W'(y_reg - (cdo_pkg::year_t'(cent_q) * cdo_pkg::year_t'(100)));

    assign leap_cur = cdo_pkg::is_leap(rem_reg, cent_reg);
    assign dim_cur  = cdo_pkg::days_in(leap_cur, m_reg);
    assign m_wrap   = (m_reg == cdo_pkg::MONTH_DEC);
    assign m_next   = m_wrap ? 4'd1 : 4'(m_reg + 4'd1);
    assign rem_inc  = (rem_reg == cdo_pkg::REM_LAST) ? '0 : 7'(rem_reg + 7'd1);
    assign cent_inc = (rem_reg == cdo_pkg::REM_LAST) ? cdo_pkg::CENT_W'(cent_reg + 1'b1)
                                                     : cent_reg;
    assign leap_inc = cdo_pkg::is_leap(rem_inc, cent_inc);
    assign leap_n   = m_wrap ? leap_inc : leap_cur;
    assign dim_n    = cdo_pkg::days_in(leap_n, m_next);
    assign d_clamp  = (d_reg > dim_n) ? dim_n : d_reg;

    always_comb
    begin
        d_step    = d_reg;
        m_step    = m_reg;
        y_step    = y_reg;
        rem_step  = rem_reg;
        cent_step = cent_reg;
        if ((op_reg == cdo_pkg::OP_MONTHS) || (d_reg == dim_cur))
        begin
            d_step = (op_reg == cdo_pkg::OP_MONTHS) ? d_clamp : 5'd1;
            m_step = m_next;
            if (m_wrap)
            begin
                y_step    = cdo_pkg::YEAR_BITS'(y_reg + 1'b1);
                rem_step  = rem_inc;
                cent_step = cent_inc;
            end
        end
        else
        begin
            d_step = 5'(d_reg + 5'd1);
        end
    end

    assign ysum = cdo_pkg::YSUM_W'(y_reg)
                + ((op_reg == cdo_pkg::OP_DECADES)
                   ? (cdo_pkg::YSUM_W'(n_reg) << 3) + (cdo_pkg::YSUM_W'(n_reg) << 1)
                   : cdo_pkg::YSUM_W'(n_reg));

    assign steps_init = (op_reg == cdo_pkg::OP_WEEKS)
                      ? cdo_pkg::STEP_W'((cdo_pkg::STEP_W'(n_reg) << 3) - cdo_pkg::STEP_W'(n_reg))
                      : cdo_pkg::STEP_W'(n_reg);

    // Weekday: with y = 100c + r, y + y/4 - y/100 + y/400 == 5c + c/4 + r + r/4 (mod 7)
    assign shift_year = (m_reg <= cdo_pkg::MONTH_FEB);
    assign w_rem  = (shift_year && (rem_reg == '0)) ? cdo_pkg::REM_LAST
                  : (shift_year ? 7'(rem_reg - 7'd1) : rem_reg);
    assign w_cent = (shift_year && (rem_reg == '0)) ? cdo_pkg::CENT_W'(cent_reg - 1'b1)
                  : cent_reg;
    assign wsum_next = cdo_pkg::SUM_W'(w_cent)
                     + cdo_pkg::SUM_W'({w_cent, 2'b00})
                     + cdo_pkg::SUM_W'(w_cent >> 2)
                     + cdo_pkg::SUM_W'(w_rem)
                     + cdo_pkg::SUM_W'(w_rem >> 2)
                     + cdo_pkg::SUM_W'(d_reg)
                     + cdo_pkg::SUM_W'(cdo_pkg::month_term(m_reg));

    assign stat.date_bad   = (y_reg == '0) || (d_reg == '0) || (d_reg > dim_cur);
    assign stat.op_steps   = (op_reg == cdo_pkg::OP_DAYS) || (op_reg == cdo_pkg::OP_WEEKS)
                          || (op_reg == cdo_pkg::OP_MONTHS);
    assign stat.op_years   = (op_reg == cdo_pkg::OP_YEARS) || (op_reg == cdo_pkg::OP_DECADES);
    assign stat.count_zero = (n_reg == '0);
    assign stat.years_ovf  = (ysum[cdo_pkg::YSUM_W-1:cdo_pkg::YEAR_BITS] != '0);
    assign stat.step_ovf   = m_wrap && (y_reg == cdo_pkg::YEAR_MAX)
                          && ((op_reg == cdo_pkg::OP_MONTHS) || (d_reg == dim_cur));
    assign stat.step_last  = (steps_reg == cdo_pkg::STEP_W'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            n_reg      <= step_count;
            d_reg      <= start_day;
            m_reg      <= start_month;
            y_reg      <= start_year;
            d0_reg     <= start_day;
            m0_reg     <= start_month;
            y0_reg     <= start_year;
            status_reg <= cdo_pkg::STATUS_OK;
        end
        if (cmd.mul)
            prod_reg <= cdo_pkg::PROD_W'(y_reg) * cdo_pkg::PROD_W'(cdo_pkg::RECIP);
        if (cmd.split)
        begin
            cent_reg <= cent_q;
            rem_reg  <= rem_q;
        end
        if (cmd.check_invalid)
            status_reg <= cdo_pkg::STATUS_BAD_DATE;
        if (cmd.years_ovf)
            status_reg <= cdo_pkg::STATUS_YEAR_OVF;
        if (cmd.years_add)
            y_reg <= cdo_pkg::YEAR_BITS'(ysum);
        if (cmd.steps_init)
        begin
            steps_reg <= steps_init;
            rem0_reg  <= rem_reg;
            cent0_reg <= cent_reg;
        end
        if (cmd.step)
        begin
            d_reg     <= d_step;
            m_reg     <= m_step;
            y_reg     <= y_step;
            rem_reg   <= rem_step;
            cent_reg  <= cent_step;
            steps_reg <= cdo_pkg::STEP_W'(steps_reg - 1'b1);
        end
        // year ran out: hand back the start date
        if (cmd.restore)
        begin
            d_reg      <= d0_reg;
            m_reg      <= m0_reg;
            y_reg      <= y0_reg;
            rem_reg    <= rem0_reg;
            cent_reg   <= cent0_reg;
            status_reg <= cdo_pkg::STATUS_YEAR_OVF;
        end
        if (cmd.wsum)
            wsum_reg <= wsum_next;
        if (cmd.wload)
        begin
            out_day_reg    <= d_reg;
            out_month_reg  <= m_reg;
            out_year_reg   <= y_reg;
            out_wday_reg   <= (status_reg == cdo_pkg::STATUS_BAD_DATE) ? '0
                                                                       : cdo_pkg::mod7(wsum_reg);
            out_status_reg <= status_reg;
        end
    end

    assign new_day   = out_day_reg;
    assign new_month = out_month_reg;
    assign new_year  = out_year_reg;
    assign weekday   = out_wday_reg;
    assign status    = out_status_reg;

endmodule

`default_nettype wire

### rtl/core/cdo_ctrl.sv
// Controller: sequences load, year split, checks, stepping and weekday for one request.
// Drives the datapath through cdo_pkg::cdo_cmd_t and owns the channel handshakes.
`default_nettype none

module cdo_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  cdo_pkg::cdo_stat_t  stat,
    output cdo_pkg::cdo_cmd_t   cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_SPLIT = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_STEP  = 7'b0010000,
        S_WSUM  = 7'b0100000,
        S_WMOD  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   years_pass_reg, years_pass_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd             = '0;
        state_next      = state_reg;
        years_pass_next = years_pass_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load        = 1'b1;
                    years_pass_next = 1'b0;
                    state_next      = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = years_pass_reg ? S_WSUM : S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_WSUM;
                if (stat.date_bad)
                begin
                    cmd.check_invalid = 1'b1;
                end
                else if (stat.op_steps)
                begin
                    if (!stat.count_zero)
                    begin
                        cmd.steps_init = 1'b1;
                        state_next     = S_STEP;
                    end
                end
                else if (stat.op_years)
                begin
                    if (stat.years_ovf)
                    begin
                        cmd.years_ovf = 1'b1;
                    end
                    else
                    begin
                        // new year needs its own split before the weekday
                        cmd.years_add   = 1'b1;
                        years_pass_next = 1'b1;
                        state_next      = S_DIV;
                    end
                end
            end
            S_STEP:
            begin
                if (stat.step_ovf)
                begin
                    cmd.restore = 1'b1;
                    state_next  = S_WSUM;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.step_last)
                        state_next = S_WSUM;
                end
            end
            S_WSUM:
            begin
                cmd.wsum   = 1'b1;
                state_next = S_WMOD;
            end
            S_WMOD:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.wload      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            years_pass_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            years_pass_reg <= years_pass_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/core/calendar_date_offset_unit.sv
// Gregorian date offset unit: adds days, weeks, months, years or decades to a date.
// A request runs DIV, SPLIT, CHECK, then STEP for a good date with a nonzero count of days,
// weeks or months, stepping one day or month per cycle, or DIV and SPLIT again for years and
// decades in range, then WSUM and WMOD. A new request is taken while the last result waits.
// rst_n clears the controller and result valid asynchronously; no memories need clearing.
// Depends on cdo_pkg, cdo_if, cdo_ctrl and cdo_datapath.
`default_nettype none

module calendar_date_offset_unit (
    input  logic      clk,
    input  logic      rst_n,
    cdo_req_if.sink   request,
    cdo_rsp_if.source result
);

    cdo_pkg::cdo_cmd_t  cmd;
    cdo_pkg::cdo_stat_t stat;
    logic               in_ready;
    logic               out_valid;

    cdo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cdo_datapath u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .stat        (stat),
        .operation   (request.operation),
        .start_day   (request.start_day),
        .start_month (request.start_month),
        .start_year  (request.start_year),
        .step_count  (request.step_count),
        .new_day     (result.new_day),
        .new_month   (result.new_month),
        .new_year    (result.new_year),
        .weekday     (result.weekday),
        .status      (result.status)
    );

    assign request.ready = in_ready;
    assign result.valid  = out_valid;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready |=> !request.ready)
        else $error("request accepted while a transaction is in progress");

    a_bad_date_weekday: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.status == cdo_pkg::STATUS_BAD_DATE) |-> (result.weekday == '0))
        else $error("invalid date result carries a nonzero weekday");

    a_ok_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.status == cdo_pkg::STATUS_OK)
        |-> (result.new_day != '0) && (result.new_month != '0) && (result.weekday != 3'd7))
        else $error("good result carries an impossible date or weekday");
`endif

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for calendar_date_offset_unit: directed and random date offsets.
// Carries its own calendar predictor; depends on cdo_pkg, cdo_if and the RTL of the unit.
`default_nettype none

module testbench;
    import cdo_pkg::*;

    localparam int unsigned TOP_YEAR    = (1 << YEAR_BITS) - 1;
    localparam int unsigned CYCLE_LIMIT = 15_000_000;
    localparam int unsigned HOLD_OFF    = 300;
    localparam int unsigned TAIL_CYCLES = 16;
    localparam int unsigned MAX_REPORTS = 10;

    localparam op_t OP_UNUSED_LO = 3'd5;
    localparam op_t OP_UNUSED_HI = 3'd7;

    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        op_t    op;
        day_t   day;
        month_t month;
        year_t  year;
        count_t count;
    } date_request_t;

    typedef struct packed {
        day_t    day;
        month_t  month;
        year_t   year;
        wday_t   wday;
        status_t status;
    } date_result_t;

    logic clk = 1'b0;
    logic rst_n;

    cdo_req_if req_ch ();
    cdo_rsp_if rsp_ch ();

    calendar_date_offset_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (rsp_ch)
    );

    always #2 clk = ~clk;

    date_result_t expected_dates [$];
    int unsigned  fail_count  = 0;
    int unsigned  hold_cycles = 0;
    bit           source_gaps = 1'b1;
    bit           sink_stalls = 1'b1;

    function automatic bit leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        if (m < 1 || m > 12)
            return 0;
        if (m == 2)
            return leap_year(y) ? 29 : 28;
        return MONTH_DAYS[m - 1];
    endfunction

    // January and February count as months 11 and 12 of the year before
    function automatic wday_t day_of_week(input int unsigned d, input int unsigned m,
                                          input int unsigned y);
        int unsigned a;
        int unsigned yy;
        int unsigned mm;
        a  = (m <= 2) ? 1 : 0;
        yy = y - a;
        mm = m + 12 * a - 2;
        return wday_t'((d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7);
    endfunction

    function automatic date_result_t offset_date(input date_request_t rq);
        int unsigned  d;
        int unsigned  m;
        int unsigned  y;
        int unsigned  steps;
        status_t      st;
        date_result_t r;
        d  = rq.day;
        m  = rq.month;
        y  = rq.year;
        st = STATUS_OK;
        if (y == 0 || m < 1 || m > 12 || d < 1 || d > month_length(y, m)) begin
            st = STATUS_BAD_DATE;
        end
        else if (rq.op == OP_DAYS || rq.op == OP_WEEKS) begin
            steps = (rq.op == OP_WEEKS) ? rq.count * 7 : rq.count;
            for (int unsigned i = 0; i < steps && st == STATUS_OK; i++) begin
                if (d == month_length(y, m)) begin
                    d = 1;
                    if (m == 12) begin
                        m = 1;
                        y++;
                        if (y > TOP_YEAR)
                            st = STATUS_YEAR_OVF;
                    end
                    else begin
                        m++;
                    end
                end
                else begin
                    d++;
                end
            end
        end
        else if (rq.op == OP_MONTHS) begin
            for (int unsigned i = 0; i < rq.count && st == STATUS_OK; i++) begin
                if (m == 12) begin
                    m = 1;
                    y++;
                    if (y > TOP_YEAR)
                        st = STATUS_YEAR_OVF;
                end
                else begin
                    m++;
                end
                // clamp to the month reached; a clamped day stays clamped
                if (d > month_length(y, m))
                    d = month_length(y, m);
            end
        end
        else if (rq.op == OP_YEARS || rq.op == OP_DECADES) begin
            y = rq.year + ((rq.op == OP_DECADES) ? 10 * rq.count : rq.count);
            if (y > TOP_YEAR)
                st = STATUS_YEAR_OVF;
        end

        if (st != STATUS_OK) begin
            d = rq.day;
            m = rq.month;
            y = rq.year;
        end
        r.day    = day_t'(d);
        r.month  = month_t'(m);
        r.year   = year_t'(y);
        r.wday   = (st == STATUS_BAD_DATE) ? wday_t'(0) : day_of_week(d, m, y);
        r.status = st;
        return r;
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("%s", msg);
        fail_count++;
    endtask

    // Offer one request and hold it until the handshake completes
    task automatic send_date(input op_t op, input day_t d, input month_t m,
                             input year_t y, input count_t n);
        date_request_t rq;
        rq = '{op: op, day: d, month: m, year: y, count: n};
        if (source_gaps && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.start_day   <= d;
        req_ch.start_month <= m;
        req_ch.start_year  <= y;
        req_ch.step_count  <= n;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_dates.push_back(offset_date(rq));
    endtask

    task automatic test_day_steps();
        send_date(OP_DAYS, 5'd31, 4'd12, 14'd1999, 10'd1);
        send_date(OP_DAYS, 5'd1, 4'd1, 14'd1, 10'd0);
        send_date(OP_DAYS, 5'd28, 4'd2, 14'd2000, 10'd1);
        send_date(OP_DAYS, 5'd31, 4'd12, 14'd16383, 10'd1);
        send_date(OP_DAYS, 5'd1, 4'd1, 14'd16382, 10'd1023);
        send_date(OP_WEEKS, 5'd1, 4'd1, 14'd2024, 10'd1023);
        send_date(OP_WEEKS, 5'd25, 4'd12, 14'd16383, 10'd1);
    endtask

    task automatic test_month_steps();
        send_date(OP_MONTHS, 5'd31, 4'd1, 14'd2023, 10'd1);
        send_date(OP_MONTHS, 5'd31, 4'd1, 14'd2024, 10'd2);
        send_date(OP_MONTHS, 5'd30, 4'd11, 14'd16383, 10'd2);
        send_date(OP_MONTHS, 5'd15, 4'd6, 14'd100, 10'd1023);
    endtask

    task automatic test_year_steps();
        // leap day carried into a common year without a clamp
        send_date(OP_YEARS, 5'd29, 4'd2, 14'd2024, 10'd1);
        send_date(OP_YEARS, 5'd1, 4'd1, 14'd15360, 10'd1023);
        send_date(OP_YEARS, 5'd1, 4'd1, 14'd15361, 10'd1023);
        send_date(OP_DECADES, 5'd5, 4'd5, 14'd16373, 10'd1);
        send_date(OP_DECADES, 5'd5, 4'd5, 14'd16374, 10'd1);
        send_date(OP_DECADES, 5'd1, 4'd3, 14'd1, 10'd1023);
    endtask

    task automatic test_bad_dates();
        send_date(OP_DAYS, 5'd0, 4'd6, 14'd2020, 10'd3);
        send_date(OP_MONTHS, 5'd10, 4'd0, 14'd2020, 10'd3);
        send_date(OP_YEARS, 5'd31, 4'd15, 14'd16383, 10'd1023);
        send_date(OP_DAYS, 5'd10, 4'd3, 14'd0, 10'd3);
        send_date(OP_WEEKS, 5'd31, 4'd4, 14'd2021, 10'd3);
        send_date(OP_DAYS, 5'd29, 4'd2, 14'd1900, 10'd1);
    endtask

    task automatic test_unused_ops();
        send_date(OP_UNUSED_LO, 5'd17, 4'd8, 14'd1987, 10'd1023);
        send_date(OP_UNUSED_HI, 5'd31, 4'd12, 14'd16383, 10'd1023);
    endtask

    // Stall the result side long enough that the unit backs up into the request side
    task automatic test_backpressure();
        source_gaps = 1'b0;
        hold_cycles = HOLD_OFF;
        repeat (10)
            send_date(op_t'($urandom_range(0, 4)), 5'($urandom_range(1, 28)),
                      4'($urandom_range(1, 12)), 14'($urandom_range(1, 9999)),
                      10'($urandom_range(0, 3)));
        source_gaps = 1'b1;
    endtask

    task automatic test_random(input int unsigned n_items);
        op_t         op;
        day_t        d;
        month_t      m;
        year_t       y;
        count_t      n;
        int unsigned len;
        repeat (n_items) begin
            if ($urandom_range(0, 7) == 0)
                op = op_t'($urandom_range(0, 7));
            else
                op = op_t'($urandom_range(0, 4));

            case ($urandom_range(0, 9))
                0, 1, 2: y = year_t'($urandom_range(1, TOP_YEAR));
                3, 4:    y = year_t'(TOP_YEAR - $urandom_range(0, 150));
                5:       y = year_t'($urandom_range(1, 400));
                6, 7:    y = year_t'($urandom_range(1580, 2420));
                8:       y = year_t'($urandom());
                default: y = ($urandom_range(0, 3) == 0) ? year_t'(0) : year_t'($urandom());
            endcase

            if ($urandom_range(0, 9) == 0)
                m = month_t'($urandom_range(0, 15));
            else
                m = month_t'($urandom_range(1, 12));

            len = month_length(y, m);
            if ($urandom_range(0, 7) == 0 || len == 0)
                d = day_t'($urandom_range(0, 31));
            else if ($urandom_range(0, 3) == 0)
                d = day_t'(len);
            else
                d = day_t'($urandom_range(1, len));

            // keep most counts short so long stepping stays rare
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: n = count_t'($urandom_range(0, 12));
                6, 7:             n = count_t'($urandom_range(0, 60));
                default:          n = count_t'($urandom());
            endcase

            send_date(op, d, m, y, n);
        end
    endtask

    // Result side: random stall bursts plus the long hold-off on request
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_cycles != 0) begin
                hold_cycles--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left != 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Check every result transaction against the oldest expected date
    always @(posedge clk) begin : result_check
        date_result_t got;
        date_result_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got = '{day: rsp_ch.new_day, month: rsp_ch.new_month, year: rsp_ch.new_year,
                    wday: rsp_ch.weekday, status: rsp_ch.status};
            if (expected_dates.size() == 0) begin
                note_failure($sformatf("unexpected result %0d-%0d-%0d wd %0d st %0d",
                             got.year, got.month, got.day, got.wday, got.status));
            end
            else begin
                want = expected_dates.pop_front();
                if (got !== want)
                    note_failure($sformatf(
                        "mismatch: expected %0d-%0d-%0d wd %0d st %0d, got %0d-%0d-%0d wd %0d st %0d",
                        want.year, want.month, want.day, want.wday, want.status,
                        got.year, got.month, got.day, got.wday, got.status));
            end
        end
    end

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.operation   <= OP_DAYS;
        req_ch.start_day   <= '0;
        req_ch.start_month <= '0;
        req_ch.start_year  <= '0;
        req_ch.step_count  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_day_steps();
        test_month_steps();
        test_year_steps();
        test_bad_dates();
        test_unused_ops();
        test_backpressure();
        test_random(470);
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        test_random(75);

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
